>>> rtl/rpt_pkg.sv
// Package with the types, constants and codes shared by the progress tracker modules.
`timescale 1ns / 1ps
`default_nettype none

package rpt_pkg;

   localparam int WINDOW_DEPTH = 256;
   localparam int RING_AW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1) > RING_AW + 1 ?
                                 $clog2(WINDOW_DEPTH + 1) : RING_AW + 1;
   localparam int WSIZE_W      = 9;
   localparam int IDX_W        = 64;
   localparam int CSR_AW       = 2;
   localparam int CSR_DW       = 32;

   localparam logic [CSR_AW-1:0]  CSR_WSIZE_ADDR = '0;
   localparam logic [WSIZE_W-1:0] WSIZE_RESET    = 9'd256;

   typedef enum logic [3:0] {
      EV_ADD        = 4'd0,
      EV_FREE_TO    = 4'd1,
      EV_FREE_FIRST = 4'd2,
      EV_PROBE      = 4'd3,
      EV_REPLICATE  = 4'd4,
      EV_SNAPSHOT   = 4'd5,
      EV_SET_NEXT   = 4'd6,
      EV_ACK        = 4'd7,
      EV_REJECT     = 4'd8,
      EV_SNAP_FAIL  = 4'd9,
      EV_PAUSE      = 4'd10,
      EV_RESUME     = 4'd11,
      EV_SET_ALIVE  = 4'd12,
      EV_QUERY      = 4'd13
   } event_type;

   typedef enum logic [1:0] {
      TM_PROBE     = 2'd0,
      TM_REPLICATE = 2'd1,
      TM_SNAPSHOT  = 2'd2
   } track_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_EXEC,
      CS_FRD,
      CS_FCMP,
      CS_RD,
      CS_CMP,
      CS_DONE
   } ctl_state_type;

   typedef struct packed {
      logic [3:0]       mode;
      logic [IDX_W-1:0] log_index;
      logic [IDX_W-1:0] leader_commit;
      logic [IDX_W-1:0] last_hint;
      logic             alive_in;
   } req_type;

   typedef struct packed {
      logic             changed;
      logic             window_full_error;
      logic             paused;
      logic             snapshot_abort;
      logic             alive_out;
      logic [1:0]       mode_out;
      logic [IDX_W-1:0] next_out;
      logic [IDX_W-1:0] match_out;
      logic [IDX_W-1:0] commit_out;
      logic [IDX_W-1:0] pending_snap_out;
      logic [8:0]       inflight_count;
   } rsp_type;

   typedef struct packed {
      logic latch_req;
      logic exec;
      logic first_load;
      logic walk_step;
      logic walk_end;
      logic load_out;
   } ctl_cmd_type;

   typedef struct packed {
      event_type         ev;
      logic              fill_zero;
      logic              walk_go;
      logic [FILL_W-1:0] fill;
      logic [FILL_W-1:0] cap;
      logic [RING_AW-1:0] head;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/rpt_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rpt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

>>> rtl/rpt_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module rpt_ctrl import rpt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = CS_EXEC;
            end
         end
         CS_EXEC: begin
            cmd.exec = 1'b1;
            if (status.ev == EV_FREE_TO && !status.fill_zero) begin
               state_in = CS_RD;
            end else if (status.ev == EV_FREE_FIRST && !status.fill_zero) begin
               state_in = CS_FRD;
            end else begin
               state_in = CS_DONE;
            end
         end
         CS_FRD: begin
            state_in = CS_FCMP;
         end
         CS_FCMP: begin
            cmd.first_load = 1'b1;
            state_in       = CS_RD;
         end
         CS_RD: begin
            state_in = CS_CMP;
         end
         CS_CMP: begin
            if (status.walk_go) begin
               cmd.walk_step = 1'b1;
               state_in      = CS_RD;
            end else begin
               cmd.walk_end = 1'b1;
               state_in     = CS_DONE;
            end
         end
         CS_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);
   end

   assign req_stall = (state_ff != CS_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/rpt_dp.sv
// Datapath holding the follower progress state, the in-flight ring and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rpt_dp import rpt_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_type            req_payload,
   output rsp_type                 rsp_payload,
   input  wire logic               cfg_we,
   input  wire logic [WSIZE_W-1:0] cfg_wdata,
   output logic      [WSIZE_W-1:0] window_size,
   input  wire ctl_cmd_type        cmd,
   output dp_status_type           status
);

   req_type            req_ff;
   rsp_type            rsp_ff;
   logic [WSIZE_W-1:0] wsize_ff;
   logic [RING_AW-1:0] head_ff, head_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]   next_ff, next_in;
   logic [IDX_W-1:0]   match_ff, match_in;
   logic [IDX_W-1:0]   commit_ff, commit_in;
   logic [IDX_W-1:0]   pend_ff, pend_in;
   track_type          mode_ff, mode_in;
   logic               pause_ff, pause_in;
   logic               alive_ff, alive_in;
   logic               changed_ff, changed_in;
   logic               ferr_ff, ferr_in;
   logic [RING_AW-1:0] pos_ff, pos_in;
   logic [FILL_W-1:0]  walk_n_ff, walk_n_in;
   logic [IDX_W-1:0]   walk_idx_ff, walk_idx_in;

   logic [FILL_W-1:0]  cap;
   logic               full;
   logic [FILL_W:0]    add_sum;
   logic [RING_AW-1:0] add_addr;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_q;
   logic [FILL_W-1:0]  pos_inc;
   logic [RING_AW-1:0] pos_wrap;
   logic [IDX_W-1:0]   li_p1, match_p1, pend_p1, hint_p1, rej_next;
   event_type          ev;

   always_comb begin
      if (wsize_ff == '0) begin
         cap = FILL_W'(1);
      end else if (32'(wsize_ff) > WINDOW_DEPTH) begin
         cap = FILL_W'(WINDOW_DEPTH);
      end else begin
         cap = FILL_W'(wsize_ff);
      end
   end

   assign full     = (fill_ff >= cap);
   assign add_sum  = (FILL_W + 1)'(head_ff) + (FILL_W + 1)'(fill_ff);
   assign add_addr = (add_sum >= (FILL_W + 1)'(cap)) ?
                     RING_AW'(add_sum - (FILL_W + 1)'(cap)) : RING_AW'(add_sum);
   assign pos_inc  = FILL_W'(pos_ff) + FILL_W'(1);
   assign pos_wrap = (pos_inc == cap) ? '0 : pos_inc[RING_AW-1:0];
   assign ev       = event_type'(req_ff.mode);
   assign li_p1    = req_ff.log_index + 64'd1;
   assign match_p1 = match_ff + 64'd1;
   assign pend_p1  = pend_ff + 64'd1;
   assign hint_p1  = req_ff.last_hint + 64'd1;
   assign rej_next = (req_ff.log_index < hint_p1) ? req_ff.log_index : hint_p1;
   assign ram_we   = cmd.exec && ev == EV_ADD && !full;

   rpt_ram #(
      .WIDTH(IDX_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_ring (
      .clock(clock),
      .we(ram_we),
      .waddr(add_addr),
      .wdata(req_ff.log_index),
      .raddr(pos_ff),
      .rdata(ram_q)
   );

   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      next_in     = next_ff;
      match_in    = match_ff;
      commit_in   = commit_ff;
      pend_in     = pend_ff;
      mode_in     = mode_ff;
      pause_in    = pause_ff;
      alive_in    = alive_ff;
      changed_in  = changed_ff;
      ferr_in     = ferr_ff;
      pos_in      = pos_ff;
      walk_n_in   = walk_n_ff;
      walk_idx_in = walk_idx_ff;
      if (cfg_we) begin
         head_in = '0;
         fill_in = '0;
      end else if (cmd.latch_req) begin
         changed_in = 1'b0;
         ferr_in    = 1'b0;
      end else if (cmd.exec) begin
         pos_in      = head_ff;
         walk_n_in   = '0;
         walk_idx_in = req_ff.log_index;
         case (ev)
            EV_ADD: begin
               if (full) begin
                  ferr_in = 1'b1;
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
            EV_PROBE, EV_REPLICATE, EV_SNAPSHOT: begin
               pause_in = 1'b0;
               pend_in  = '0;
               fill_in  = '0;
               head_in  = '0;
               if (ev == EV_PROBE) begin
                  mode_in = TM_PROBE;
                  if (mode_ff == TM_SNAPSHOT && pend_p1 > match_p1) begin
                     next_in = pend_p1;
                  end else begin
                     next_in = match_p1;
                  end
               end else if (ev == EV_REPLICATE) begin
                  mode_in = TM_REPLICATE;
                  next_in = match_p1;
               end else begin
                  mode_in = TM_SNAPSHOT;
                  pend_in = req_ff.log_index;
               end
            end
            EV_SET_NEXT: begin
               next_in = li_p1;
            end
            EV_ACK: begin
               if (commit_ff < req_ff.leader_commit) begin
                  commit_in = req_ff.leader_commit;
               end
               if (match_ff < req_ff.log_index) begin
                  match_in   = req_ff.log_index;
                  changed_in = 1'b1;
                  pause_in   = 1'b0;
               end
               if (next_ff < li_p1) begin
                  next_in = li_p1;
               end
            end
            EV_REJECT: begin
               if (mode_ff == TM_REPLICATE) begin
                  if (commit_ff < req_ff.leader_commit) begin
                     commit_in = req_ff.leader_commit;
                  end
                  if (req_ff.log_index > match_ff) begin
                     next_in    = match_p1;
                     changed_in = 1'b1;
                  end
               end else if (next_ff - 64'd1 == req_ff.log_index) begin
                  next_in    = (rej_next == '0) ? 64'd1 : rej_next;
                  commit_in  = req_ff.leader_commit;
                  pause_in   = 1'b0;
                  changed_in = 1'b1;
               end
            end
            EV_SNAP_FAIL: begin
               pend_in = '0;
            end
            EV_PAUSE: begin
               pause_in = 1'b1;
            end
            EV_RESUME: begin
               pause_in = 1'b0;
            end
            EV_SET_ALIVE: begin
               alive_in = req_ff.alive_in;
            end
            default: begin
            end
         endcase
      end else if (cmd.first_load) begin
         walk_idx_in = ram_q;
      end else if (cmd.walk_step) begin
         walk_n_in = walk_n_ff + FILL_W'(1);
         pos_in    = pos_wrap;
      end else if (cmd.walk_end) begin
         fill_in = fill_ff - walk_n_ff;
         head_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff   <= WSIZE_RESET;
         head_ff    <= '0;
         fill_ff    <= '0;
         next_ff    <= '0;
         match_ff   <= '0;
         commit_ff  <= '0;
         pend_ff    <= '0;
         mode_ff    <= TM_PROBE;
         pause_ff   <= 1'b0;
         alive_ff   <= 1'b0;
         changed_ff <= 1'b0;
         ferr_ff    <= 1'b0;
      end else begin
         if (cfg_we) begin
            wsize_ff <= cfg_wdata;
         end
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         next_ff    <= next_in;
         match_ff   <= match_in;
         commit_ff  <= commit_in;
         pend_ff    <= pend_in;
         mode_ff    <= mode_in;
         pause_ff   <= pause_in;
         alive_ff   <= alive_in;
         changed_ff <= changed_in;
         ferr_ff    <= ferr_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      walk_n_ff   <= walk_n_in;
      walk_idx_ff <= walk_idx_in;
      if (cmd.latch_req) begin
         req_ff <= req_payload;
      end
      if (cmd.load_out) begin
         rsp_ff.changed           <= changed_ff;
         rsp_ff.window_full_error <= ferr_ff;
         case (mode_ff)
            TM_PROBE:     rsp_ff.paused <= pause_ff;
            TM_SNAPSHOT:  rsp_ff.paused <= 1'b1;
            default:      rsp_ff.paused <= full;
         endcase
         rsp_ff.snapshot_abort    <= (mode_ff == TM_SNAPSHOT) && (match_ff >= pend_ff);
         rsp_ff.alive_out         <= alive_ff;
         rsp_ff.mode_out          <= mode_ff;
         rsp_ff.next_out          <= next_ff;
         rsp_ff.match_out         <= match_ff;
         rsp_ff.commit_out        <= commit_ff;
         rsp_ff.pending_snap_out  <= pend_ff;
         rsp_ff.inflight_count    <= 9'(fill_ff);
      end
   end

   assign rsp_payload      = rsp_ff;
   assign window_size      = wsize_ff;
   assign status.ev        = ev;
   assign status.fill_zero = (fill_ff == '0);
   assign status.walk_go   = (walk_n_ff < fill_ff) && !(walk_idx_ff < ram_q);
   assign status.fill      = fill_ff;
   assign status.cap       = cap;
   assign status.head      = head_ff;

endmodule

`default_nettype wire

>>> rtl/replication_progress_tracker.sv
// Top level of the follower replication progress tracker.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_payload (req_type)
//   rsp_      out        rsp_valid / rsp_stall  rsp_payload (rsp_type)
//   CSR       in         psel/penable/pwrite    window_size at byte address 0
//
// A request is accepted in the idle state, executes in the exec state and is loaded into the
// result register in the done state, which waits while an earlier result is still stalled in
// the output register; the next request is taken back in idle. On a non-empty window free_to
// walks the ring with a read and a compare state per step, one step per released entry plus
// the step that stops the walk, and free_first first reads the oldest entry into the walk.
// Reset is synchronous and active high; the ring contents are not cleared.
// A new request is taken while an earlier result is still stalled on rsp_; the next
// result waits in the controller until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module replication_progress_tracker import rpt_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire req_type           req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready
);

   ctl_cmd_type        cmd;
   dp_status_type      status;
   logic               cfg_we;
   logic [WSIZE_W-1:0] window_size;

   assign cfg_we = psel && penable && pwrite && (paddr == CSR_WSIZE_ADDR);
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_WSIZE_ADDR) ? CSR_DW'(window_size) : '0;

   rpt_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status(status),
      .cmd(cmd)
   );

   rpt_dp u_dp (
      .clock(clock),
      .reset(reset),
      .req_payload(req_payload),
      .rsp_payload(rsp_payload),
      .cfg_we(cfg_we),
      .cfg_wdata(pwdata[WSIZE_W-1:0]),
      .window_size(window_size),
      .cmd(cmd),
      .status(status)
   );

   a_fill_in_cap: assert property (@(posedge clock) disable iff (reset)
      status.fill <= status.cap)
      else $error("In-flight fill exceeds the window capacity.");

   a_head_in_cap: assert property (@(posedge clock) disable iff (reset)
      FILL_W'(status.head) < status.cap)
      else $error("Ring head lies outside the window capacity.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Request channel ready again right after an accepted request.");

endmodule

`default_nettype wire

>>> verif/progress_status_checker.sv
// Checker that predicts the tracker status for every request and compares each result.
`timescale 1ns / 1ps

module progress_status_checker import rpt_pkg::*; #(
   parameter logic [CSR_AW-1:0] WSIZE_ADDR = '0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire req_type           req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire rsp_type           rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   input  wire logic [CSR_DW-1:0] prdata,
   input  wire logic              pready,
   output int unsigned            errors,
   output int unsigned            outstanding,
   output int unsigned            results_seen,
   output logic [IDX_W-1:0]       next_now,
   output logic [IDX_W-1:0]       match_now
);

   logic [IDX_W-1:0] ring [WINDOW_DEPTH];
   int unsigned      head;
   int unsigned      fill;
   logic [IDX_W-1:0] nxt;
   logic [IDX_W-1:0] mat;
   logic [IDX_W-1:0] cmt;
   logic [IDX_W-1:0] pend;
   track_type        tmode;
   logic             pause_f;
   logic             alive_f;
   logic [8:0]       wsize;
   rsp_type          expected_status [$];
   rsp_type          want;

   function automatic int unsigned win_cap();
      if (wsize == 0) return 1;
      if (wsize > WINDOW_DEPTH) return WINDOW_DEPTH;
      return wsize;
   endfunction

   function automatic void release_upto(input logic [IDX_W-1:0] idx);
      int unsigned cap;
      int unsigned pos;
      int unsigned n;
      cap = win_cap();
      pos = head % cap;
      n = 0;
      if (fill == 0 || idx < ring[pos]) return;
      while (n < fill && idx >= ring[pos]) begin
         n++;
         pos = (pos + 1) % cap;
      end
      fill = fill - n;
      head = pos;
   endfunction

   function automatic void enter_track(input track_type m);
      pause_f = 1'b0;
      pend = '0;
      tmode = m;
      fill = 0;
      head = 0;
   endfunction

   function automatic rsp_type apply_event(input req_type r);
      rsp_type          o;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      int unsigned      cap;
      o = '0;
      cap = win_cap();
      case (r.mode)
         EV_ADD: begin
            if (fill >= cap) begin
               o.window_full_error = 1'b1;
            end else begin
               ring[(head + fill) % cap] = r.log_index;
               fill++;
            end
         end
         EV_FREE_TO: release_upto(r.log_index);
         EV_FREE_FIRST: begin
            if (fill != 0) release_upto(ring[head % cap]);
         end
         EV_PROBE: begin
            a = mat + 64'd1;
            b = pend + 64'd1;
            if (tmode == TM_SNAPSHOT && b > a) a = b;
            enter_track(TM_PROBE);
            nxt = a;
         end
         EV_REPLICATE: begin
            enter_track(TM_REPLICATE);
            nxt = mat + 64'd1;
         end
         EV_SNAPSHOT: begin
            enter_track(TM_SNAPSHOT);
            pend = r.log_index;
         end
         EV_SET_NEXT: nxt = r.log_index + 64'd1;
         EV_ACK: begin
            a = r.log_index + 64'd1;
            if (cmt < r.leader_commit) cmt = r.leader_commit;
            if (mat < r.log_index) begin
               mat = r.log_index;
               o.changed = 1'b1;
               pause_f = 1'b0;
            end
            if (nxt < a) nxt = a;
         end
         EV_REJECT: begin
            if (tmode == TM_REPLICATE) begin
               if (cmt < r.leader_commit) cmt = r.leader_commit;
               if (r.log_index > mat) begin
                  nxt = mat + 64'd1;
                  o.changed = 1'b1;
               end
            end else if (nxt - 64'd1 == r.log_index) begin
               b = r.last_hint + 64'd1;
               nxt = (r.log_index < b) ? r.log_index : b;
               if (nxt == '0) nxt = 64'd1;
               cmt = r.leader_commit;
               pause_f = 1'b0;
               o.changed = 1'b1;
            end
         end
         EV_SNAP_FAIL: pend = '0;
         EV_PAUSE: pause_f = 1'b1;
         EV_RESUME: pause_f = 1'b0;
         EV_SET_ALIVE: alive_f = r.alive_in;
         default: ;
      endcase
      case (tmode)
         TM_PROBE: o.paused = pause_f;
         TM_SNAPSHOT: o.paused = 1'b1;
         default: o.paused = (fill >= cap);
      endcase
      o.snapshot_abort = (tmode == TM_SNAPSHOT) && (mat >= pend);
      o.alive_out = alive_f;
      o.mode_out = tmode;
      o.next_out = nxt;
      o.match_out = mat;
      o.commit_out = cmt;
      o.pending_snap_out = pend;
      o.inflight_count = fill[8:0];
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [IDX_W-1:0] exp_v,
                                       input logic [IDX_W-1:0] got_v);
      if (exp_v !== got_v) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_status.delete();
         head = 0;
         fill = 0;
         nxt = '0;
         mat = '0;
         cmt = '0;
         pend = '0;
         tmode = TM_PROBE;
         pause_f = 1'b0;
         alive_f = 1'b0;
         wsize = WSIZE_RESET;
         errors = 0;
         results_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_status.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_payload);
            end else begin
               want = expected_status.pop_front();
               check_field("changed", want.changed, rsp_payload.changed);
               check_field("window_full_error", want.window_full_error,
                           rsp_payload.window_full_error);
               check_field("paused", want.paused, rsp_payload.paused);
               check_field("snapshot_abort", want.snapshot_abort, rsp_payload.snapshot_abort);
               check_field("alive_out", want.alive_out, rsp_payload.alive_out);
               check_field("mode_out", want.mode_out, rsp_payload.mode_out);
               check_field("next_out", want.next_out, rsp_payload.next_out);
               check_field("match_out", want.match_out, rsp_payload.match_out);
               check_field("commit_out", want.commit_out, rsp_payload.commit_out);
               check_field("pending_snap_out", want.pending_snap_out,
                           rsp_payload.pending_snap_out);
               check_field("inflight_count", want.inflight_count, rsp_payload.inflight_count);
            end
         end
         if (req_valid && !req_stall) expected_status.push_back(apply_event(req_payload));
         if (psel && penable && pready && paddr == WSIZE_ADDR) begin
            if (pwrite) begin
               wsize = pwdata[8:0];
               fill = 0;
               head = 0;
            end else begin
               check_field("window_size readback", {{(CSR_DW - 9){1'b0}}, wsize}, prdata);
            end
         end
      end
      outstanding = expected_status.size();
      next_now = nxt;
      match_now = mat;
   end

endmodule

>>> verif/replication_progress_tracker_test.sv
// Testbench top that drives requests and register writes into the progress tracker.
`timescale 1ns / 1ps

module replication_progress_tracker_test;
   import rpt_pkg::*;

   localparam logic [CSR_AW-1:0] WSIZE_ADDR = '0;
   localparam logic [3:0]        EV_SPARE_LO = 4'd14;
   localparam logic [3:0]        EV_SPARE_HI = 4'd15;
   localparam logic [IDX_W-1:0]  ALL_ONES = '1;
   localparam int                HOLD_CYCLES = 300;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_payload;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_payload;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   int unsigned       errors;
   int unsigned       outstanding;
   int unsigned       results_seen;
   logic [IDX_W-1:0]  next_now;
   logic [IDX_W-1:0]  match_now;

   int                send_idle_pct = 0;
   int                take_idle_pct = 0;
   int                hold_left = 0;
   int unsigned       sent_count = 0;
   logic [IDX_W-1:0]  add_seq;
   logic [8:0]        chunk_size [6] = '{9'd0, 9'd5, 9'd511, 9'd1, 9'd256, 9'd17};

   replication_progress_tracker u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   progress_status_checker #(.WSIZE_ADDR(WSIZE_ADDR)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .errors       (errors),
      .outstanding  (outstanding),
      .results_seen (results_seen),
      .next_now     (next_now),
      .match_now    (match_now)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL replication_progress_tracker");
      $finish;
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < take_idle_pct);
         end
      end
   end

   task automatic send_req(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic issue(input logic [3:0] mode, input logic [IDX_W-1:0] li,
                        input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] lh,
                        input logic al);
      req_type r;
      r.mode = mode;
      r.log_index = li;
      r.leader_commit = lc;
      r.last_hint = lh;
      r.alive_in = al;
      send_req(r);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [8:0] size);
      logic [CSR_DW-1:0] word;
      word = $urandom;
      word[8:0] = size;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= WSIZE_ADDR;
      pwdata <= word;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic req_type pick_event();
      req_type     r;
      int unsigned roll;
      r.mode = EV_QUERY;
      r.log_index = {$urandom, $urandom};
      r.leader_commit = {$urandom, $urandom};
      r.last_hint = {$urandom, $urandom};
      r.alive_in = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 26) begin
         r.mode = EV_ADD;
         add_seq = add_seq + 64'($urandom_range(3, 1));
         if ($urandom_range(9) != 0) r.log_index = add_seq;
      end else if (roll < 34) begin
         r.mode = EV_FREE_TO;
         if ($urandom_range(7) != 0) r.log_index = add_seq - 64'($urandom_range(8));
      end else if (roll < 40) begin
         r.mode = EV_FREE_FIRST;
      end else if (roll < 43) begin
         r.mode = EV_PROBE;
      end else if (roll < 46) begin
         r.mode = EV_REPLICATE;
      end else if (roll < 49) begin
         r.mode = EV_SNAPSHOT;
         if ($urandom_range(3) != 0)
            r.log_index = match_now + 64'($urandom_range(6)) - 64'd3;
      end else if (roll < 53) begin
         r.mode = EV_SET_NEXT;
         if ($urandom_range(3) != 0) r.log_index = match_now + 64'($urandom_range(4));
      end else if (roll < 68) begin
         r.mode = EV_ACK;
         if ($urandom_range(5) != 0)
            r.log_index = match_now + 64'($urandom_range(4)) - 64'd1;
         if ($urandom_range(1) != 0)
            r.leader_commit = r.log_index - 64'($urandom_range(3));
      end else if (roll < 80) begin
         r.mode = EV_REJECT;
         if ($urandom_range(9) < 7) r.log_index = next_now - 64'd1;
         else if ($urandom_range(1) != 0)
            r.log_index = match_now + 64'($urandom_range(3));
         if ($urandom_range(3) != 0) r.last_hint = r.log_index - 64'($urandom_range(5));
         if ($urandom_range(1) != 0) r.leader_commit = match_now - 64'($urandom_range(3));
      end else if (roll < 83) begin
         r.mode = EV_SNAP_FAIL;
      end else if (roll < 86) begin
         r.mode = EV_PAUSE;
      end else if (roll < 89) begin
         r.mode = EV_RESUME;
      end else if (roll < 94) begin
         r.mode = EV_SET_ALIVE;
      end else if (roll < 97) begin
         r.mode = EV_QUERY;
      end else begin
         r.mode = $urandom_range(1) ? EV_SPARE_LO : EV_SPARE_HI;
      end
      return r;
   endfunction

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      add_seq = 64'd100;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 18;
      take_idle_pct = 87;
      csr_access(1'b0, 9'd0);
      csr_access(1'b1, 9'd2);
      csr_access(1'b0, 9'd0);

      issue(EV_QUERY, '0, '0, '0, 1'b0);
      issue(EV_SET_ALIVE, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
      issue(EV_ADD, 64'd5, '0, '0, 1'b0);
      issue(EV_ADD, ALL_ONES, '0, '0, 1'b0);
      issue(EV_ADD, 64'd9, '0, '0, 1'b0);
      issue(EV_FREE_FIRST, '0, '0, '0, 1'b0);
      issue(EV_FREE_TO, '0, '0, '0, 1'b0);
      issue(EV_FREE_TO, ALL_ONES, '0, '0, 1'b0);
      issue(EV_FREE_FIRST, '0, '0, '0, 1'b0);
      issue(EV_REPLICATE, '0, '0, '0, 1'b0);
      issue(EV_ADD, 64'd1, '0, '0, 1'b0);
      issue(EV_ADD, 64'd2, '0, '0, 1'b0);
      issue(EV_ACK, 64'd10, 64'd4, '0, 1'b0);
      issue(EV_REJECT, 64'd20, 64'd8, '0, 1'b0);
      issue(EV_SNAPSHOT, 64'd50, '0, '0, 1'b0);
      issue(EV_SNAP_FAIL, '0, '0, '0, 1'b0);
      issue(EV_SNAPSHOT, 64'd5, '0, '0, 1'b0);
      issue(EV_PROBE, '0, '0, '0, 1'b0);
      issue(EV_PAUSE, '0, '0, '0, 1'b0);
      issue(EV_REJECT, 64'd10, 64'd2, 64'd3, 1'b0);
      issue(EV_SET_NEXT, ALL_ONES, '0, '0, 1'b0);
      issue(EV_REJECT, ALL_ONES, '0, ALL_ONES, 1'b0);
      issue(EV_ACK, ALL_ONES, ALL_ONES, '0, 1'b0);
      issue(EV_RESUME, '0, '0, '0, 1'b0);
      issue(EV_SET_ALIVE, '0, '0, '0, 1'b0);
      issue(EV_SPARE_LO, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
      issue(EV_SPARE_HI, '0, '0, '0, 1'b0);

      for (int chunk = 0; chunk < 6; chunk++) begin
         wait_quiet();
         case (chunk / 2)
            0: begin
               send_idle_pct = 18;
               take_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               take_idle_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         add_seq = (chunk == 2) ? ALL_ONES - 64'd40 : 64'($urandom_range(1000));
         csr_access(1'b1, chunk_size[chunk]);
         csr_access(1'b0, 9'd0);
         for (int k = 0; k < 70; k++) begin
            if (chunk == 4 && k == 20) hold_left = HOLD_CYCLES;
            send_req(pick_event());
         end
      end
      wait_quiet();

      $display("Summary: %0d results checked from %0d requests, window sizes 0 to 511,",
               results_seen, sent_count);
      $display("every event code, skewed idle mixes and one long response hold.");
      if (errors == 0) begin
         $display("PASS replication_progress_tracker");
      end else begin
         $display("FAIL replication_progress_tracker");
      end
      $finish;
   end

endmodule
